FILE: rtl/bta_pkg.sv
`timescale 1ns / 1ps
package bta_pkg;

  localparam int NUM_SLOTS  = 5;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int ROLL_W     = 16;
  localparam int MISS_W     = 8;
  localparam int TRK_OUT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd1;

  localparam logic [MISS_W-1:0] MISS_LIMIT_RST      = 8'd10;
  localparam logic [ROLL_W-1:0] MATCH_THRESHOLD_RST = 16'd6554;

  localparam logic signed [TRK_OUT_W-1:0] NO_TRACK = -4'sd1;

  typedef struct packed {
    logic                 cmd;
    logic [NUM_SLOTS-1:0] visible_mask;
    logic [ROLL_W-1:0]    roll_slot0;
    logic [ROLL_W-1:0]    roll_slot1;
    logic [ROLL_W-1:0]    roll_slot2;
    logic [ROLL_W-1:0]    roll_slot3;
    logic [ROLL_W-1:0]    roll_slot4;
  } in_item_t;

  typedef struct packed {
    logic signed [TRK_OUT_W-1:0] track_of_slot0;
    logic signed [TRK_OUT_W-1:0] track_of_slot1;
    logic signed [TRK_OUT_W-1:0] track_of_slot2;
    logic signed [TRK_OUT_W-1:0] track_of_slot3;
    logic signed [TRK_OUT_W-1:0] track_of_slot4;
    logic [NUM_SLOTS-1:0]        active_tracks;
  } out_item_t;

  typedef logic [NUM_SLOTS-1:0][ROLL_W-1:0] roll_vec_t;

  // Sequencer to lane
  typedef struct packed {
    logic              age;
    logic              take;
    logic [ROLL_W-1:0] roll;
  } lane_ctl_t;

  // Lane to merge
  typedef struct packed {
    logic              active;
    logic [MISS_W-1:0] missed;
    logic              hit;
    logic [ROLL_W-1:0] gap;
    logic [SLOT_W-1:0] slot;
  } lane_stat_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] trk;
    logic [SLOT_W-1:0] slot;
  } match_res_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] trk;
  } fill_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_EVAL,
    ST_PICK,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/bta_lane.sv
`timescale 1ns / 1ps
module bta_lane
  import bta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [MISS_W-1:0]    miss_limit,
  input  logic [ROLL_W-1:0]    match_threshold,
  input  roll_vec_t            slot_roll,
  input  logic [NUM_SLOTS-1:0] slot_elig,
  input  logic                 lane_en,
  input  lane_ctl_t            ctl,
  output lane_stat_t           stat
);

  logic              active_r, active_nxt;
  logic [ROLL_W-1:0] roll_r, roll_nxt;
  logic [MISS_W-1:0] missed_r, missed_nxt;
  logic [MISS_W-1:0] miss_inc;
  logic              hit_r, hit_nxt;
  logic [ROLL_W-1:0] dist_r, dist_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ROLL_W-1:0] diff;
  logic [ROLL_W-1:0] gap;

  // Closest eligible slot to this track, lowest slot on ties
  always_comb begin
    hit_nxt  = 1'b0;
    dist_nxt = '0;
    slot_nxt = '0;
    diff     = '0;
    gap      = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      diff = slot_roll[s] - roll_r;
      gap  = diff[ROLL_W-1] ? (~diff + ROLL_W'(1)) : diff;
      if (slot_elig[s] && (gap < match_threshold) && (!hit_nxt || (gap < dist_nxt))) begin
        hit_nxt  = 1'b1;
        dist_nxt = gap;
        slot_nxt = SLOT_W'(s);
      end
    end
    if (!(active_r && lane_en)) begin
      hit_nxt = 1'b0;
    end
  end

  always_comb begin
    active_nxt = active_r;
    roll_nxt   = roll_r;
    missed_nxt = missed_r;
    miss_inc   = (missed_r == '1) ? missed_r : missed_r + MISS_W'(1);
    if (ctl.age && active_r) begin
      if (miss_inc > miss_limit) begin
        // drop the track
        active_nxt = 1'b0;
        roll_nxt   = '0;
        missed_nxt = '0;
      end else begin
        missed_nxt = miss_inc;
      end
    end
    if (ctl.take) begin
      active_nxt = 1'b1;
      roll_nxt   = ctl.roll;
      missed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      roll_r   <= '0;
      missed_r <= '0;
      hit_r    <= 1'b0;
    end else begin
      active_r <= active_nxt;
      roll_r   <= roll_nxt;
      missed_r <= missed_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    slot_r <= slot_nxt;
  end

  assign stat.active = active_r;
  assign stat.missed = missed_r;
  assign stat.hit    = hit_r;
  assign stat.gap    = dist_r;
  assign stat.slot   = slot_r;

endmodule

FILE: rtl/bta_merge.sv
`timescale 1ns / 1ps
module bta_merge
  import bta_pkg::*;
(
  input  lane_stat_t [NUM_SLOTS-1:0] stat,
  input  logic [NUM_SLOTS-1:0]       trk_used,
  output match_res_t                 match,
  output fill_res_t                  fill
);

  logic [ROLL_W-1:0] best_dist;
  logic              free_found;
  logic [SLOT_W-1:0] free_trk;
  logic              most_found;
  logic [MISS_W-1:0] most;
  logic [SLOT_W-1:0] most_trk;

  // Smallest distance over the lanes, lowest track on ties
  always_comb begin
    match     = '0;
    best_dist = '0;
    for (int t = 0; t < NUM_SLOTS; t++) begin
      if (stat[t].hit && (!match.hit || (stat[t].gap < best_dist))) begin
        match.hit  = 1'b1;
        match.trk  = SLOT_W'(t);
        match.slot = stat[t].slot;
        best_dist  = stat[t].gap;
      end
    end
  end

  // First free track, else the unused track missed longest
  always_comb begin
    free_found = 1'b0;
    free_trk   = '0;
    most_found = 1'b0;
    most       = '0;
    most_trk   = '0;
    for (int t = 0; t < NUM_SLOTS; t++) begin
      if (!stat[t].active && !free_found) begin
        free_found = 1'b1;
        free_trk   = SLOT_W'(t);
      end
      if (!trk_used[t] && (!most_found || (stat[t].missed > most))) begin
        most_found = 1'b1;
        most       = stat[t].missed;
        most_trk   = SLOT_W'(t);
      end
    end
    fill.found = free_found || most_found;
    fill.trk   = free_found ? free_trk : most_trk;
  end

endmodule

FILE: rtl/blade_track_association.sv
`timescale 1ns / 1ps
// Age-only items run the age step, then load the result register; associate items age
// the tracks, run greedy match rounds (an evaluation state in which the track lanes
// register their candidates, then a pick state through the merge), fill the slots in
// turn and load the result register. A new item is taken once the sequencer is back in
// idle, the result register holding the previous result meanwhile.
// Reset (synchronous, rst_n low) clears all tracks and restores the default registers.
module blade_track_association
  import bta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t                      state_r, state_nxt;
  in_item_t                    in_r;
  logic [NUM_SLOTS-1:0]        slot_used_r;
  logic [NUM_SLOTS-1:0]        trk_used_r;
  logic signed [TRK_OUT_W-1:0] assign_r [NUM_SLOTS];
  logic [SLOT_W-1:0]           fill_slot_r;
  out_item_t                   out_r;
  logic                        out_valid_r;
  logic [MISS_W-1:0]           miss_limit_r;
  logic [ROLL_W-1:0]           thr_r;

  roll_vec_t                   slot_roll;
  logic [NUM_SLOTS-1:0]        slot_elig;
  logic [NUM_SLOTS-1:0]        active_vec;
  lane_ctl_t [NUM_SLOTS-1:0]   lane_ctl;
  lane_stat_t [NUM_SLOTS-1:0]  lane_stat;
  match_res_t                  match;
  fill_res_t                   fill;
  logic                        in_accept;
  logic                        age;
  logic                        take;
  logic [SLOT_W-1:0]           take_trk;
  logic [SLOT_W-1:0]           take_slot;
  logic                        load_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_roll[0] = in_r.roll_slot0;
  assign slot_roll[1] = in_r.roll_slot1;
  assign slot_roll[2] = in_r.roll_slot2;
  assign slot_roll[3] = in_r.roll_slot3;
  assign slot_roll[4] = in_r.roll_slot4;
  assign slot_elig    = in_r.visible_mask & ~slot_used_r;

  for (genvar t = 0; t < NUM_SLOTS; t++) begin : g_lane
    assign lane_ctl[t].age  = age;
    assign lane_ctl[t].take = take && (take_trk == SLOT_W'(t));
    assign lane_ctl[t].roll = slot_roll[take_slot];
    assign active_vec[t]    = lane_stat[t].active;

    bta_lane u_lane (
      .clk             (clk),
      .rst_n           (rst_n),
      .miss_limit      (miss_limit_r),
      .match_threshold (thr_r),
      .slot_roll       (slot_roll),
      .slot_elig       (slot_elig),
      .lane_en         (!trk_used_r[t]),
      .ctl             (lane_ctl[t]),
      .stat            (lane_stat[t])
    );
  end

  bta_merge u_merge (
    .stat     (lane_stat),
    .trk_used (trk_used_r),
    .match    (match),
    .fill     (fill)
  );

  always_comb begin
    state_nxt = state_r;
    age       = 1'b0;
    take      = 1'b0;
    take_trk  = '0;
    take_slot = '0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_AGE;
      end
      ST_AGE: begin
        age       = 1'b1;
        state_nxt = in_r.cmd ? ST_EVAL : ST_DONE;
      end
      ST_EVAL: begin
        // lanes register their best candidates
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (match.hit) begin
          take      = 1'b1;
          take_trk  = match.trk;
          take_slot = match.slot;
          state_nxt = ST_EVAL;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        take_slot = fill_slot_r;
        if (slot_elig[fill_slot_r] && fill.found) begin
          take     = 1'b1;
          take_trk = fill.trk;
        end
        if (fill_slot_r == SLOT_W'(NUM_SLOTS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      slot_used_r  <= '0;
      trk_used_r   <= '0;
      fill_slot_r  <= '0;
      miss_limit_r <= MISS_LIMIT_RST;
      thr_r        <= MATCH_THRESHOLD_RST;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        slot_used_r <= '0;
        trk_used_r  <= '0;
        fill_slot_r <= '0;
      end else begin
        if (take) begin
          trk_used_r[take_trk]   <= 1'b1;
          slot_used_r[take_slot] <= 1'b1;
        end
        if (state_r == ST_FILL) fill_slot_r <= fill_slot_r + SLOT_W'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MISS_LIMIT:      miss_limit_r <= cfg_wdata[MISS_W-1:0];
          REG_MATCH_THRESHOLD: thr_r        <= cfg_wdata[ROLL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
      for (int s = 0; s < NUM_SLOTS; s++) assign_r[s] <= NO_TRACK;
    end else if (take) begin
      assign_r[take_slot] <= TRK_OUT_W'(take_trk);
    end
    if (load_out) begin
      out_r.track_of_slot0 <= assign_r[0];
      out_r.track_of_slot1 <= assign_r[1];
      out_r.track_of_slot2 <= assign_r[2];
      out_r.track_of_slot3 <= assign_r[3];
      out_r.track_of_slot4 <= assign_r[4];
      out_r.active_tracks  <= active_vec;
    end
  end

endmodule

FILE: sim/bta_assoc_checker.sv
`timescale 1ns / 1ps
module bta_assoc_checker
  import bta_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           results_done,
  output int unsigned           errors
);

  logic [MISS_W-1:0] lim_missed;
  logic [ROLL_W-1:0] thr_match;
  logic              trk_on     [NUM_SLOTS];
  logic [ROLL_W-1:0] trk_angle  [NUM_SLOTS];
  logic [MISS_W-1:0] trk_misses [NUM_SLOTS];
  out_item_t         frame_q[$];
  int unsigned       mismatches;
  int unsigned       seen;

  function automatic void claim_track(int t, logic [ROLL_W-1:0] r);
    trk_on[t]     = 1'b1;
    trk_angle[t]  = r;
    trk_misses[t] = '0;
  endfunction

  function automatic logic signed [TRK_OUT_W-1:0] slot_track(out_item_t r, int s);
    case (s)
      0:       return r.track_of_slot0;
      1:       return r.track_of_slot1;
      2:       return r.track_of_slot2;
      3:       return r.track_of_slot3;
      default: return r.track_of_slot4;
    endcase
  endfunction

  // Age the table, then for associate items match greedily and fill leftovers; updates the table.
  function automatic out_item_t associate_frame(in_item_t f);
    logic [ROLL_W-1:0] roll [NUM_SLOTS];
    int                track_slots [NUM_SLOTS];
    bit                slot_taken [NUM_SLOTS];
    bit                trk_taken [NUM_SLOTS];
    int                best_t, best_s, most, pick;
    logic [ROLL_W:0]   best, d;
    logic [ROLL_W-1:0] diff;
    bit                found;
    out_item_t         r;
    roll[0] = f.roll_slot0;
    roll[1] = f.roll_slot1;
    roll[2] = f.roll_slot2;
    roll[3] = f.roll_slot3;
    roll[4] = f.roll_slot4;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      track_slots[s] = -1;
      slot_taken[s]  = 1'b0;
      trk_taken[s]   = 1'b0;
    end
    for (int t = 0; t < NUM_SLOTS; t++) begin
      if (trk_on[t]) begin
        if (trk_misses[t] != 8'hFF) trk_misses[t] = trk_misses[t] + 1'b1;
        if (trk_misses[t] > lim_missed) begin
          trk_on[t]     = 1'b0;
          trk_angle[t]  = '0;
          trk_misses[t] = '0;
        end
      end
    end
    if (f.cmd) begin
      found = 1'b1;
      while (found) begin
        best_t = -1;
        best_s = -1;
        best   = {1'b0, thr_match};
        for (int t = 0; t < NUM_SLOTS; t++) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (trk_on[t] && !trk_taken[t] && f.visible_mask[s] && !slot_taken[s]) begin
              // fold the wrapped difference into a half turn
              diff = roll[s] - trk_angle[t];
              d = diff[ROLL_W-1] ? 17'h10000 - {1'b0, diff} : {1'b0, diff};
              if (d < best) begin
                best   = d;
                best_t = t;
                best_s = s;
              end
            end
          end
        end
        found = (best_t >= 0);
        if (found) begin
          claim_track(best_t, roll[best_s]);
          track_slots[best_s] = best_t;
          trk_taken[best_t]   = 1'b1;
          slot_taken[best_s]  = 1'b1;
        end
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (f.visible_mask[s] && !slot_taken[s]) begin
          pick = -1;
          for (int t = 0; t < NUM_SLOTS; t++) begin
            if (pick < 0 && !trk_on[t]) pick = t;
          end
          // table full: steal the stalest track not used this frame
          if (pick < 0) begin
            most = -1;
            for (int t = 0; t < NUM_SLOTS; t++) begin
              if (!trk_taken[t] && int'(trk_misses[t]) > most) begin
                most = int'(trk_misses[t]);
                pick = t;
              end
            end
          end
          if (pick >= 0) begin
            claim_track(pick, roll[s]);
            track_slots[s]  = pick;
            trk_taken[pick] = 1'b1;
          end
        end
      end
    end
    r.track_of_slot0 = track_slots[0][TRK_OUT_W-1:0];
    r.track_of_slot1 = track_slots[1][TRK_OUT_W-1:0];
    r.track_of_slot2 = track_slots[2][TRK_OUT_W-1:0];
    r.track_of_slot3 = track_slots[3][TRK_OUT_W-1:0];
    r.track_of_slot4 = track_slots[4][TRK_OUT_W-1:0];
    for (int t = 0; t < NUM_SLOTS; t++) r.active_tracks[t] = trk_on[t];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      lim_missed = MISS_LIMIT_RST;
      thr_match  = MATCH_THRESHOLD_RST;
      for (int t = 0; t < NUM_SLOTS; t++) begin
        trk_on[t]     = 1'b0;
        trk_angle[t]  = '0;
        trk_misses[t] = '0;
      end
      frame_q.delete();
      mismatches = 0;
      seen       = 0;
      results_done <= 0;
      errors       <= 0;
    end else begin
      // check the result first: it can never belong to an item taken at this edge
      if (out_valid && !out_stall) begin
        seen++;
        if (frame_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with no item pending: %h",
                                         seen, out_data);
        end else begin
          want = frame_q.pop_front();
          bad  = (want.active_tracks !== out_data.active_tracks);
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_track(want, s) !== slot_track(out_data, s)) bad = 1'b1;
          end
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected tracks %0d %0d %0d %0d %0d active %b",
                       seen, slot_track(want, 0), slot_track(want, 1), slot_track(want, 2),
                       slot_track(want, 3), slot_track(want, 4), want.active_tracks);
              $display("result %0d: got      tracks %0d %0d %0d %0d %0d active %b",
                       seen, slot_track(out_data, 0), slot_track(out_data, 1),
                       slot_track(out_data, 2), slot_track(out_data, 3),
                       slot_track(out_data, 4), out_data.active_tracks);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MISS_LIMIT:      lim_missed = cfg_wdata[MISS_W-1:0];
          REG_MATCH_THRESHOLD: thr_match  = cfg_wdata[ROLL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) frame_q.push_back(associate_frame(in_data));
      results_done <= seen;
      errors       <= mismatches + frame_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bta_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           results_done;
  int unsigned           errors;

  int unsigned       sent_count;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                thr_now;
  int                slot_shift;
  logic [ROLL_W-1:0] blade_phase;
  int                phase_limits [4] = '{10, 0, 254, 3};
  int                phase_thrs [4]   = '{6554, 3000, 32768, 500};

  localparam int BLADE_STEP = 13107;  // a fifth of a turn

  always #6 clk = ~clk;

  blade_track_association dut (.*);

  bta_assoc_checker assoc_check (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  function automatic in_item_t pack_frame(input logic cmd, input logic [NUM_SLOTS-1:0] mask,
                                          input logic [ROLL_W-1:0] r0, r1, r2, r3, r4);
    in_item_t f;
    f.cmd          = cmd;
    f.visible_mask = mask;
    f.roll_slot0   = r0;
    f.roll_slot1   = r1;
    f.roll_slot2   = r2;
    f.roll_slot3   = r3;
    f.roll_slot4   = r4;
    return f;
  endfunction

  // Mostly a spinning five-blade rotor with jitter; some noise frames.
  function automatic in_item_t spin_frame();
    logic [ROLL_W-1:0]    r [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] mask;
    int                   spread, k, sum;
    if ($urandom_range(99) < 12)
      return pack_frame(1'($urandom_range(1)), NUM_SLOTS'($urandom_range(31)),
                        ROLL_W'($urandom_range(65535)), ROLL_W'($urandom_range(65535)),
                        ROLL_W'($urandom_range(65535)), ROLL_W'($urandom_range(65535)),
                        ROLL_W'($urandom_range(65535)));
    blade_phase = blade_phase + ROLL_W'($urandom_range(900));
    if ($urandom_range(9) == 0) slot_shift = $urandom_range(4);
    for (k = 0; k < NUM_SLOTS; k++) begin
      case ($urandom_range(9))
        0, 1:    spread = thr_now + $urandom_range(4) - 2;
        2:       spread = $urandom_range(16000);
        default: spread = $urandom_range(150);
      endcase
      if ($urandom_range(1)) spread = -spread;
      sum  = int'(blade_phase) + ((k + slot_shift) % NUM_SLOTS) * BLADE_STEP + spread;
      r[k] = sum[ROLL_W-1:0];
    end
    // duplicate a roll now and then to force ties
    if ($urandom_range(7) == 0) begin
      k = $urandom_range(1, NUM_SLOTS - 1);
      r[k] = r[k-1];
    end
    case ($urandom_range(3))
      0:       mask = '1;
      1:       mask = 5'b00001 << $urandom_range(NUM_SLOTS - 1);
      default: mask = NUM_SLOTS'($urandom_range(31));
    endcase
    return pack_frame($urandom_range(9) != 0, mask, r[0], r[1], r[2], r[3], r[4]);
  endfunction

  task automatic send_frame(input in_item_t f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Hold off until every item sent has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_done < sent_count) @(posedge clk);
  endtask

  task automatic write_regs(input int limit, input int thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MISS_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_index <= REG_MATCH_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_now = thr;
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_stall   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    sent_count  = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 81;
    thr_now     = int'(MATCH_THRESHOLD_RST);
    slot_shift  = 0;
    blade_phase = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: empty table, fill, wrap, ties, stealing
    send_frame(pack_frame(1'b0, 5'h1F, 0, 0, 0, 0, 0));
    send_frame(pack_frame(1'b1, 5'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_frame(pack_frame(1'b1, 5'h1F, 0, 13107, 26214, 39321, 52428));
    send_frame(pack_frame(1'b1, 5'h1F, 65436, 13207, 26314, 39421, 52528));
    send_frame(pack_frame(1'b1, 5'h1F, 52428, 65436, 13207, 26214, 39321));
    send_frame(pack_frame(1'b1, 5'h03, 65436, 65436, 0, 0, 0));
    send_frame(pack_frame(1'b1, 5'h01, 100, 0, 0, 0, 0));
    send_frame(pack_frame(1'b0, 5'h00, 0, 0, 0, 0, 0));
    send_frame(pack_frame(1'b0, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_frame(pack_frame(1'b1, 5'h1F, 32768, 45875, 58982, 6553, 19660));
    send_frame(pack_frame(1'b1, 5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // zero threshold and immediate drop
    wait_for_results();
    write_regs(0, 0);
    send_frame(pack_frame(1'b1, 5'h1F, 0, 0, 0, 0, 0));
    send_frame(pack_frame(1'b1, 5'h15, 1, 2, 3, 4, 5));
    send_frame(pack_frame(1'b0, 5'h1F, 0, 0, 0, 0, 0));
    send_frame(pack_frame(1'b1, 5'h0A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // widest threshold, longest life
    wait_for_results();
    write_regs(254, 32768);
    send_frame(pack_frame(1'b1, 5'h1F, 0, 13107, 26214, 39321, 52428));
    send_frame(pack_frame(1'b1, 5'h1F, 32768, 45875, 58982, 6553, 19660));
    send_frame(pack_frame(1'b1, 5'h01, 32768, 0, 0, 0, 0));
    send_frame(pack_frame(1'b0, 5'h00, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      wait_for_results();
      if (ph < 4) write_regs(phase_limits[ph], phase_thrs[ph]);
      else write_regs($urandom_range(254), $urandom_range(32768));
      if (ph < 2) begin
        tx_idle_pct = 24;
        rx_idle_pct = 81;
      end else if (ph < 4) begin
        tx_idle_pct = 81;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      repeat (176) begin
        if ($urandom_range(59) == 0) wait_for_results();
        send_frame(spin_frame());
      end
    end

    wait_for_results();
    rx_idle_pct = 0;
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
